>>> design/cst_pkg.sv
// cst_pkg: shared types and constants of the script tokenizer
// lexer modes, token kinds, byte classes, command word table, queue item
// no dependencies
package cst_pkg;

    // lexer mode kept by the back end
    typedef enum logic [2:0] {
        M_BLANK,
        M_SLASH,
        M_COMMENT,
        M_CSTAR,
        M_STRING,
        M_SESC,
        M_NUMBER,
        M_IDENT
    } lex_mode_t;

    // token kind codes as seen on the output channel
    typedef enum logic [2:0] {
        K_CMD,
        K_STR,
        K_NUM,
        K_ID,
        K_EOF,
        K_SLASH,
        K_DOT,
        K_UNK
    } tok_kind_t;

    // byte classes decided by the front end
    typedef enum logic [3:0] {
        CC_BLANK,
        CC_SLASH,
        CC_STAR,
        CC_QUOTE,
        CC_BSLASH,
        CC_DIGIT,
        CC_LETTER,
        CC_DOT,
        CC_OTHER
    } char_class_t;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HIGH   = 8'h80;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // command words, upper case, zero padded
    localparam int WORD_COUNT = 7;
    localparam int WORD_SLOTS = 7;
    localparam logic [7:0] WORD_CHAR [WORD_COUNT][WORD_SLOTS] = '{
        '{"S", "E", "R", "V", "E", "R", CH_NUL},
        '{"Q", "U", "I", "T", CH_NUL, CH_NUL, CH_NUL},
        '{"S", "E", "N", "D", CH_NUL, CH_NUL, CH_NUL},
        '{"R", "E", "C", "E", "I", "V", "E"},
        '{"G", "E", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"I", "N", "P", "U", "T", CH_NUL, CH_NUL},
        '{"O", "U", "T", "P", "U", "T", CH_NUL}
    };
    localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
        3'd6, 3'd4, 3'd4, 3'd7, 3'd3, 3'd5, 3'd6
    };
    localparam logic [2:0] CMD_NONE = 3'd0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // one classified script byte
    typedef struct packed {
        logic [7:0]  raw;
        logic [7:0]  upper;
        logic [7:0]  esc;
        char_class_t cls;
        logic        eof;
    } lex_item_t;

    // one result token
    typedef struct packed {
        tok_kind_t   kind;
        logic [2:0]  cmd;
        logic [7:0]  text;
        logic        last;
        logic        trunc;
        logic [31:0] num;
    } tok_t;

endpackage

>>> design/cst_in_if.sv
// cst_in_if: input byte channel of the script tokenizer
// valid/ready handshake with the byte and the end flag; no dependencies
interface cst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

>>> design/cst_tok_if.sv
// cst_tok_if: token output channel of the script tokenizer
// valid/ready handshake with the token fields; no dependencies
interface cst_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [2:0]  command_id;
    logic [7:0]  text_byte;
    logic        string_last;
    logic        string_truncated;
    logic [31:0] number_value;

    modport source (
        output valid, output token_kind, output command_id, output text_byte,
        output string_last, output string_truncated, output number_value,
        input ready
    );
    modport sink (
        input valid, input token_kind, input command_id, input text_byte,
        input string_last, input string_truncated, input number_value,
        output ready
    );
endinterface

>>> design/command_script_tokenizer_core.sv
// channel  | dir | beat contents
// in_ch    | in  | in_byte, end_of_input
// tok_ch   | out | token_kind, command_id, text_byte,
//          |     | string_last, string_truncated, number_value
//
// one byte is taken per cycle while the queue has room; a byte that ends a
// pending token and also gives a token of its own (dot, unknown byte, eof)
// stays in the lexer until both of its token beats are sent
// the queue of four bytes lets the input keep flowing while such a byte waits
// tokens leave through one output register, one beat per cycle while tok_ch is ready
// rst_n clears the lexer to blank skipping and empties the queue
// a stalled output holds its beat and backs up into the queue
//
// command_script_tokenizer_core: top level of the script tokenizer
// depends on cst_pkg, cst_in_if, cst_tok_if, cst_front, cst_queue, cst_back
module command_script_tokenizer_core #(
    parameter int IDENT_MAX  = 29,
    parameter int STRING_MAX = 255
) (
    input  logic      clk,
    input  logic      rst_n,
    cst_in_if.sink    in_ch,
    cst_tok_if.source tok_ch
);
    import cst_pkg::*;

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_valid;
    lex_item_t front_item;
    lex_item_t head_item;

    // byte intake and classification
    cst_front u_front (
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    // decoupling queue
    cst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_valid),
        .head      (head_item)
    );

    // lexer and token output
    cst_back #(
        .IDENT_MAX  (IDENT_MAX),
        .STRING_MAX (STRING_MAX)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (queue_valid),
        .it      (head_item),
        .pop     (pop),
        .tok_ch  (tok_ch)
    );
endmodule

>>> design/cst_front.sv
// cst_front: accepts script bytes and classifies them for the lexer
// depends on cst_pkg and cst_in_if
module cst_front (
    cst_in_if.sink          in_ch,
    input  logic            queue_full,
    output logic            push,
    output cst_pkg::lex_item_t item
);
    import cst_pkg::*;

    // take a beat whenever the queue has room
    assign in_ch.ready = !queue_full;
    assign push        = in_ch.valid && !queue_full;

    // classification
    always_comb
    begin
        item.raw = in_ch.in_byte;
        item.eof = in_ch.end_of_input || (in_ch.in_byte == CH_NUL);

        // upper-case fold
        if (in_ch.in_byte >= CH_LO_A && in_ch.in_byte <= CH_LO_Z)
        begin
            item.upper = in_ch.in_byte - CASE_GAP;
        end
        else
        begin
            item.upper = in_ch.in_byte;
        end

        // escape translation
        case (in_ch.in_byte)
            CH_LO_N: item.esc = CH_LF;
            CH_LO_B: item.esc = CH_BS;
            CH_LO_T: item.esc = CH_TAB;
            default: item.esc = in_ch.in_byte;
        endcase

        // byte class
        if (in_ch.in_byte <= CH_SPACE || in_ch.in_byte >= CH_HIGH)
        begin
            item.cls = CC_BLANK;
        end
        else if (in_ch.in_byte >= CH_ZERO && in_ch.in_byte <= CH_NINE)
        begin
            item.cls = CC_DIGIT;
        end
        else if (item.upper >= CH_UP_A && item.upper <= CH_UP_Z)
        begin
            item.cls = CC_LETTER;
        end
        else
        begin
            unique case (in_ch.in_byte)
                CH_SLASH:  item.cls = CC_SLASH;
                CH_STAR:   item.cls = CC_STAR;
                CH_QUOTE:  item.cls = CC_QUOTE;
                CH_BSLASH: item.cls = CC_BSLASH;
                CH_DOT:    item.cls = CC_DOT;
                default:   item.cls = CC_OTHER;
            endcase
        end
    end
endmodule

>>> design/cst_queue.sv
// cst_queue: short queue of classified bytes between front and back
// depends on cst_pkg
module cst_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cst_pkg::lex_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output cst_pkg::lex_item_t head
);
    import cst_pkg::*;

    lex_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

>>> design/cst_back.sv
// cst_back: lexer state machine and token output register
// depends on cst_pkg and cst_tok_if
module cst_back #(
    parameter int IDENT_MAX  = 29,
    parameter int STRING_MAX = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cst_pkg::lex_item_t it,
    output logic               pop,
    cst_tok_if.source          tok_ch
);
    import cst_pkg::*;

    localparam int LEN_W = $clog2(IDENT_MAX + 1);
    localparam int CNT_W = $clog2(STRING_MAX + 1);

    lex_mode_t              mode_reg,  mode_next;
    logic [LEN_W-1:0]       len_reg,   len_next;
    logic [CNT_W-1:0]       cnt_reg,   cnt_next;
    logic [31:0]            accum_reg, accum_next;
    logic                   trunc_reg, trunc_next;
    logic [WORD_COUNT-1:0]  match_reg, match_next;
    logic                   sub_reg;
    logic                   out_valid_reg;
    tok_t                   out_tok_reg;

    logic        pre_v;
    tok_t        pre_t;
    logic        fall;
    logic        st_v;
    tok_t        st_t;
    logic [2:0]  word_id;
    logic [35:0] wide;
    logic        emit_v;
    logic        last_beat;
    logic        slot_free;
    logic        go;
    tok_t        cur_tok;

    // command word lookup
    always_comb
    begin
        word_id = CMD_NONE;
        for (int w = WORD_COUNT - 1; w >= 0; w--)
        begin
            if (match_reg[w] && len_reg == LEN_W'(WORD_LEN[w]))
            begin
                word_id = 3'(w + 1);
            end
        end
    end

    // decimal accumulate
    assign wide = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                + 36'(it.raw[3:0]);

    // next state and tokens for the head item
    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        accum_next = accum_reg;
        trunc_next = trunc_reg;
        match_next = match_reg;
        pre_v      = 1'b0;
        pre_t      = '0;
        fall       = 1'b0;
        st_v       = 1'b0;
        st_t       = '0;

        unique case (mode_reg)
            M_SLASH:
            begin
                if (!it.eof && it.cls == CC_STAR)
                begin
                    mode_next = M_COMMENT;
                end
                else
                begin
                    pre_v      = 1'b1;
                    pre_t.kind = K_SLASH;
                    fall       = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (it.eof)
                begin
                    fall = 1'b1;
                end
                else if (it.cls == CC_STAR)
                begin
                    mode_next = M_CSTAR;
                end
            end
            M_CSTAR:
            begin
                if (it.eof)
                begin
                    fall = 1'b1;
                end
                else if (it.cls == CC_SLASH)
                begin
                    mode_next = M_BLANK;
                end
                else if (it.cls != CC_STAR)
                begin
                    mode_next = M_COMMENT;
                end
            end
            M_STRING, M_SESC:
            begin
                if (it.eof || (mode_reg == M_STRING && it.cls == CC_QUOTE))
                begin
                    // close the string
                    pre_v       = 1'b1;
                    pre_t.kind  = K_STR;
                    pre_t.last  = 1'b1;
                    pre_t.trunc = trunc_reg;
                    mode_next   = M_BLANK;
                    cnt_next    = '0;
                    trunc_next  = 1'b0;
                    fall        = it.eof;
                end
                else if (mode_reg == M_STRING && it.cls == CC_BSLASH)
                begin
                    mode_next = M_SESC;
                end
                else
                begin
                    // store one string byte or drop it past the cap
                    mode_next = M_STRING;
                    if (cnt_reg < CNT_W'(STRING_MAX))
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        pre_v      = 1'b1;
                        pre_t.kind = K_STR;
                        pre_t.text = (mode_reg == M_SESC) ? it.esc : it.raw;
                    end
                    else
                    begin
                        trunc_next = 1'b1;
                    end
                end
            end
            M_NUMBER:
            begin
                if (!it.eof && it.cls == CC_DIGIT)
                begin
                    accum_next = (wide[35:32] != 4'h0) ? '1 : wide[31:0];
                end
                else
                begin
                    pre_v      = 1'b1;
                    pre_t.kind = K_NUM;
                    pre_t.num  = accum_reg;
                    accum_next = '0;
                    fall       = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (!it.eof && (it.cls == CC_LETTER || it.cls == CC_DIGIT)
                    && len_reg < LEN_W'(IDENT_MAX))
                begin
                    len_next = len_reg + 1'b1;
                    for (int w = 0; w < WORD_COUNT; w++)
                    begin
                        match_next[w] = match_reg[w] && (len_reg < LEN_W'(WORD_SLOTS))
                            && (WORD_CHAR[w][len_reg[2:0]] == it.upper);
                    end
                end
                else
                begin
                    pre_v      = 1'b1;
                    pre_t.kind = (word_id != CMD_NONE) ? K_CMD : K_ID;
                    pre_t.cmd  = word_id;
                    len_next   = '0;
                    fall       = 1'b1;
                end
            end
            default:
            begin
                fall = 1'b1;
            end
        endcase

        // fresh byte while skipping blanks
        if (fall)
        begin
            mode_next = M_BLANK;
            if (it.eof)
            begin
                len_next   = '0;
                cnt_next   = '0;
                accum_next = '0;
                trunc_next = 1'b0;
                st_v       = 1'b1;
                st_t.kind  = K_EOF;
            end
            else
            begin
                unique case (it.cls)
                    CC_SLASH:
                    begin
                        mode_next = M_SLASH;
                    end
                    CC_QUOTE:
                    begin
                        mode_next  = M_STRING;
                        cnt_next   = '0;
                        trunc_next = 1'b0;
                    end
                    CC_DIGIT:
                    begin
                        mode_next  = M_NUMBER;
                        accum_next = 32'(it.raw[3:0]);
                    end
                    CC_LETTER:
                    begin
                        mode_next = M_IDENT;
                        len_next  = LEN_W'(1);
                        for (int w = 0; w < WORD_COUNT; w++)
                        begin
                            match_next[w] = (WORD_CHAR[w][0] == it.upper);
                        end
                    end
                    CC_DOT:
                    begin
                        st_v      = 1'b1;
                        st_t.kind = K_DOT;
                    end
                    CC_BLANK:
                    begin
                        st_v = 1'b0;
                    end
                    default:
                    begin
                        st_v      = 1'b1;
                        st_t.kind = K_UNK;
                        st_t.text = it.raw;
                    end
                endcase
            end
        end
    end

    // beat sequencing: a two-token item takes two beats
    assign emit_v    = pre_v || st_v;
    assign last_beat = !(pre_v && st_v) || sub_reg;
    assign slot_free = !out_valid_reg || tok_ch.ready;
    assign go        = q_valid && (!emit_v || slot_free);
    assign pop       = go && last_beat;
    assign cur_tok   = (pre_v && !sub_reg) ? pre_t : st_t;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_BLANK;
            len_reg   <= '0;
            cnt_reg   <= '0;
            accum_reg <= '0;
            trunc_reg <= 1'b0;
            match_reg <= '0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg  <= mode_next;
                len_reg   <= len_next;
                cnt_reg   <= cnt_next;
                accum_reg <= accum_next;
                trunc_reg <= trunc_next;
                match_reg <= match_next;
                sub_reg   <= 1'b0;
            end
            else if (go)
            begin
                sub_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && emit_v)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tok_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit_v)
        begin
            out_tok_reg <= cur_tok;
        end
    end

    assign tok_ch.valid            = out_valid_reg;
    assign tok_ch.token_kind       = out_tok_reg.kind;
    assign tok_ch.command_id       = out_tok_reg.cmd;
    assign tok_ch.text_byte        = out_tok_reg.text;
    assign tok_ch.string_last      = out_tok_reg.last;
    assign tok_ch.string_truncated = out_tok_reg.trunc;
    assign tok_ch.number_value     = out_tok_reg.num;
endmodule
